FILE: src/cfmb_pkg.sv
// Shared types and constants for the capture frequency meter with bar graph.
// Used by cfmb_mul, cfmb_div and capture_frequency_meter_bargraph_core.
package cfmb_pkg;

   localparam int TIMER_WIDTH = 32;
   localparam int LAMP_COUNT  = 4;
   localparam int LAMP_SHOWN  = (LAMP_COUNT < 4) ? LAMP_COUNT : 4;

   localparam logic [31:0] TIMER_MASK = 32'((64'd1 << TIMER_WIDTH) - 64'd1);

   localparam logic [31:0] CLOCK_RATE_RESET = 32'd100000000;
   localparam logic [16:0] PRESCALE_RESET   = 17'd1;
   localparam logic [29:0] LEVEL_STEP_RESET = 30'd1000;

   localparam int MUL_STEPS = 17;
   localparam int MUL_CNT_W = 5;
   localparam int DIV_STEPS = 32;
   localparam int DIV_CNT_W = 5;
   localparam int LAMP_CNT_W = 3;
   localparam int THR_W      = 33;

   typedef enum logic [1:0] {
      CSR_CLOCK_RATE = 2'd0,
      CSR_PRESCALE   = 2'd1,
      CSR_LEVEL_STEP = 2'd2
   } cfmb_csr_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_DIV,
      ST_LAMP,
      ST_DONE
   } cfmb_state_type;

   typedef struct packed {
      logic busy;
      logic done;
   } cfmb_unit_status_type;

endpackage

FILE: src/cfmb_mul.sv
// Bit-serial shift-add multiplier, one multiplier bit per cycle, product mod 2^32.
// Depends on cfmb_pkg.
module cfmb_mul (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [31:0]                   multiplicand,
   input  logic [16:0]                   multiplier,
   output logic [31:0]                   product,
   output cfmb_pkg::cfmb_unit_status_type status
);

   logic [31:0]                     acc_ff, acc_in;
   logic [31:0]                     mcand_ff, mcand_in;
   logic [16:0]                     mplier_ff, mplier_in;
   logic [cfmb_pkg::MUL_CNT_W-1:0]  cnt_ff, cnt_in;
   logic                            busy_ff, busy_in;
   logic                            done_ff, done_in;

   always_comb begin
      acc_in    = acc_ff;
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      cnt_in    = cnt_ff;
      busy_in   = busy_ff;
      done_in   = 1'b0;
      if (start) begin
         acc_in    = '0;
         mcand_in  = multiplicand;
         mplier_in = multiplier;
         cnt_in    = '0;
         busy_in   = 1'b1;
      end else if (busy_ff) begin
         if (mplier_ff[0]) begin
            acc_in = acc_ff + mcand_ff;
         end
         mcand_in  = {mcand_ff[30:0], 1'b0};
         mplier_in = {1'b0, mplier_ff[16:1]};
         cnt_in    = cnt_ff + 1'b1;
         if (cnt_ff == cfmb_pkg::MUL_CNT_W'(cfmb_pkg::MUL_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff    <= acc_in;
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
   end

   assign product     = acc_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule

FILE: src/cfmb_div.sv
// Restoring divider, one quotient bit per cycle, 32-bit unsigned operands.
// Depends on cfmb_pkg.
module cfmb_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [31:0]                   dividend,
   input  logic [31:0]                   divisor,
   output logic [31:0]                   quotient,
   output cfmb_pkg::cfmb_unit_status_type status
);

   logic [31:0]                     rem_ff, rem_in;
   logic [31:0]                     quo_ff, quo_in;
   logic [31:0]                     dsor_ff, dsor_in;
   logic [cfmb_pkg::DIV_CNT_W-1:0]  cnt_ff, cnt_in;
   logic                            busy_ff, busy_in;
   logic                            done_ff, done_in;
   logic [32:0]                     shifted;
   logic                            q_bit;
   logic [32:0]                     reduced;

   always_comb begin
      shifted = {rem_ff, quo_ff[31]};
      q_bit   = (shifted >= {1'b0, dsor_ff});
      reduced = shifted - {1'b0, dsor_ff};
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dsor_in = dsor_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         dsor_in = divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = q_bit ? reduced[31:0] : shifted[31:0];
         quo_in = {quo_ff[30:0], q_bit};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == cfmb_pkg::DIV_CNT_W'(cfmb_pkg::DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      dsor_ff <= dsor_in;
   end

   assign quotient    = quo_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule

FILE: src/capture_frequency_meter_bargraph_core.sv
// Reciprocal frequency meter with bar-graph lamps: sequencer, registers, lamp compare.
// Depends on cfmb_pkg, cfmb_mul and cfmb_div.
//
//   channel  dir  signals                     payload
//   req      in   req_tvalid/tready/tdata     capture_time[31:0]
//   rsp      out  rsp_tvalid/tready/tdata     measured_hz[31:0], lamp_bar[35:32]
//                 rsp_tuser                   zero_period
//   csr      in   csr_we/index/wdata          clock_rate, prescale, level_step
//
// Each capture runs 17 multiply steps, 32 divide steps and a lamp compare per shown lamp,
// plus handoffs; a zero period skips divider and lamps. Captures are taken only in idle.
// The first capture after reset is only stored and gives no item.
// Reset is synchronous; config registers return to their defaults.
// One output register: a new capture is taken while a result waits on rsp.
module capture_frequency_meter_bargraph_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // capture_time[31:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // measured_hz[31:0], lamp_bar[35:32], zero pad
   output logic [0:0]  rsp_tuser,   // zero_period[0]
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   cfmb_pkg::cfmb_state_type       state_ff, state_in;
   logic [31:0]                    clock_rate_ff, clock_rate_in;
   logic [16:0]                    prescale_ff, prescale_in;
   logic [29:0]                    step_ff, step_in;
   logic                           have_prev_ff, have_prev_in;
   logic [31:0]                    prev_ff, prev_in;
   logic [31:0]                    hz_ff, hz_in;
   logic [3:0]                     bar_ff, bar_in;
   logic                           zero_ff, zero_in;
   logic [cfmb_pkg::THR_W-1:0]     thr_ff, thr_in;
   logic [cfmb_pkg::LAMP_CNT_W-1:0] lamp_cnt_ff, lamp_cnt_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [39:0]                    rsp_data_ff, rsp_data_in;
   logic                           rsp_zero_ff, rsp_zero_in;

   logic                           accept;
   logic [31:0]                    now;
   logic [31:0]                    diff;
   logic                           mul_start, div_start;
   logic [31:0]                    product, quotient;
   cfmb_pkg::cfmb_unit_status_type mul_st, div_st;
   logic                           hit;

   assign accept = req_tvalid && req_tready;
   assign now    = req_tdata & cfmb_pkg::TIMER_MASK;
   assign diff   = (now - prev_ff) & cfmb_pkg::TIMER_MASK;

   cfmb_mul u_mul (
      .clock        (clock),
      .reset        (reset),
      .start        (mul_start),
      .multiplicand (diff),
      .multiplier   (prescale_ff),
      .product      (product),
      .status       (mul_st)
   );

   cfmb_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (clock_rate_ff),
      .divisor  (product),
      .quotient (quotient),
      .status   (div_st)
   );

   always_comb begin
      clock_rate_in = clock_rate_ff;
      prescale_in   = prescale_ff;
      step_in       = step_ff;
      if (csr_we) begin
         unique case (csr_index)
            cfmb_pkg::CSR_CLOCK_RATE: clock_rate_in = csr_wdata;
            cfmb_pkg::CSR_PRESCALE:   prescale_in   = csr_wdata[16:0];
            cfmb_pkg::CSR_LEVEL_STEP: step_in       = csr_wdata[29:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in     = state_ff;
      have_prev_in = have_prev_ff;
      prev_in      = prev_ff;
      hz_in        = hz_ff;
      bar_in       = bar_ff;
      zero_in      = zero_ff;
      thr_in       = thr_ff;
      lamp_cnt_in  = lamp_cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_zero_in  = rsp_zero_ff;
      req_tready   = 1'b0;
      mul_start    = 1'b0;
      div_start    = 1'b0;
      hit          = ({1'b0, hz_ff} >= thr_ff);
      unique case (state_ff)
         cfmb_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               prev_in      = now;
               have_prev_in = 1'b1;
               if (have_prev_ff) begin
                  mul_start = 1'b1;
                  bar_in    = '0;
                  zero_in   = 1'b0;
                  state_in  = cfmb_pkg::ST_MUL;
               end
            end
         end
         cfmb_pkg::ST_MUL: begin
            if (mul_st.done) begin
               if (product == '0) begin
                  hz_in    = '0;
                  bar_in   = '0;
                  zero_in  = 1'b1;
                  state_in = cfmb_pkg::ST_DONE;
               end else begin
                  div_start = 1'b1;
                  state_in  = cfmb_pkg::ST_DIV;
               end
            end
         end
         cfmb_pkg::ST_DIV: begin
            if (div_st.done) begin
               hz_in       = quotient;
               thr_in      = cfmb_pkg::THR_W'(step_ff);
               lamp_cnt_in = '0;
               state_in    = cfmb_pkg::ST_LAMP;
            end
         end
         cfmb_pkg::ST_LAMP: begin
            bar_in[lamp_cnt_ff[1:0]] = hit;
            thr_in      = thr_ff + cfmb_pkg::THR_W'(step_ff);
            lamp_cnt_in = lamp_cnt_ff + 1'b1;
            if (lamp_cnt_ff == cfmb_pkg::LAMP_CNT_W'(cfmb_pkg::LAMP_SHOWN - 1)) begin
               state_in = cfmb_pkg::ST_DONE;
            end
         end
         cfmb_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {4'b0, bar_ff, hz_ff};
               rsp_zero_in  = zero_ff;
               state_in     = cfmb_pkg::ST_IDLE;
            end
         end
         default: state_in = cfmb_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= cfmb_pkg::ST_IDLE;
         clock_rate_ff <= cfmb_pkg::CLOCK_RATE_RESET;
         prescale_ff   <= cfmb_pkg::PRESCALE_RESET;
         step_ff       <= cfmb_pkg::LEVEL_STEP_RESET;
         have_prev_ff  <= 1'b0;
         prev_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
         lamp_cnt_ff   <= '0;
      end else begin
         state_ff      <= state_in;
         clock_rate_ff <= clock_rate_in;
         prescale_ff   <= prescale_in;
         step_ff       <= step_in;
         have_prev_ff  <= have_prev_in;
         prev_ff       <= prev_in;
         rsp_valid_ff  <= rsp_valid_in;
         lamp_cnt_ff   <= lamp_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      hz_ff       <= hz_in;
      bar_ff      <= bar_in;
      zero_ff     <= zero_in;
      thr_ff      <= thr_in;
      rsp_data_ff <= rsp_data_in;
      rsp_zero_ff <= rsp_zero_in;
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = rsp_data_ff;
   assign rsp_tuser[0] = rsp_zero_ff;

   a_zero_clears: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[0]) |-> (rsp_tdata == '0))
      else $error("zero period item carries nonzero data");

   a_bar_thermo: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (!(rsp_tdata[33] && !rsp_tdata[32]) &&
                      !(rsp_tdata[34] && !rsp_tdata[33]) &&
                      !(rsp_tdata[35] && !rsp_tdata[34])))
      else $error("lamp bar is not a thermometer code");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (accept && have_prev_ff) |=> !req_tready)
      else $error("capture taken while measurement in progress");

   a_mul_handoff: assert property (@(posedge clock) disable iff (reset)
      (state_ff == cfmb_pkg::ST_MUL && mul_st.done) |=>
      (state_ff == cfmb_pkg::ST_DIV || state_ff == cfmb_pkg::ST_DONE))
      else $error("multiply result not handed off");

   a_units_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(mul_st.busy && div_st.busy))
      else $error("multiplier and divider busy together");

endmodule

FILE: bench/tb_capture_frequency_meter_bargraph_core.sv
// Self-checking bench for capture_frequency_meter_bargraph_core: streams capture timestamps,
// predicts frequency, lamp bar and zero-period flag per item and checks every result.
// Depends on cfmb_pkg and the core RTL only.
module tb_capture_frequency_meter_bargraph_core;

   localparam int CLOCK_PERIOD   = 12;
   localparam int RESET_CYCLES   = 7;
   localparam int DRAIN_CYCLES   = 100;
   localparam int TIMEOUT_CYCLES = 400000;
   localparam int MAX_REPORTS    = 10;
   localparam logic [1:0] CSR_UNMAPPED = 2'd3;

   typedef struct packed {
      logic [31:0] measured_hz;
      logic [3:0]  lamp_bar;
      logic        zero_period;
   } meter_reading_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;
   logic [0:0]  rsp_tuser;
   logic        csr_we = 1'b0;
   logic [1:0]  csr_index = '0;
   logic [31:0] csr_wdata = '0;

   // predictor state and register copy
   logic        have_prev;
   logic [31:0] prev_capture;
   logic [31:0] cfg_clock_rate;
   logic [16:0] cfg_prescale;
   logic [29:0] cfg_level_step;

   logic [31:0]       capture_queue[$];
   meter_reading_type expected_readings[$];
   logic [31:0]       last_capture;

   int  idle_max = 5;
   int  req_gap = 0;
   int  rsp_stall = 0;
   logic req_taken = 1'b0;
   int  errors = 0;
   int  items_sent = 0;
   int  readings_checked = 0;
   int  zero_flags = 0;
   int  csr_writes = 0;

   capture_frequency_meter_bargraph_core u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   function automatic logic predict_meter(input logic [31:0] capture,
                                          output meter_reading_type rd);
      logic [31:0] now;
      logic [31:0] diff;
      logic [31:0] period;
      logic [63:0] threshold;
      now = capture & cfmb_pkg::TIMER_MASK;
      rd = '0;
      if (!have_prev) begin
         have_prev = 1'b1;
         prev_capture = now;
         return 1'b0;
      end
      diff = (now - prev_capture) & cfmb_pkg::TIMER_MASK;
      period = 32'(64'(diff) * 64'(cfg_prescale));
      prev_capture = now;
      if (period == 32'd0) begin
         rd.zero_period = 1'b1;
         return 1'b1;
      end
      rd.measured_hz = cfg_clock_rate / period;
      for (int i = 0; i < cfmb_pkg::LAMP_SHOWN; i++) begin
         threshold = 64'(cfg_level_step) * 64'(i + 1);
         if (64'(rd.measured_hz) >= threshold) rd.lamp_bar[i] = 1'b1;
      end
      return 1'b1;
   endfunction

   // monitor: check results first, then predict for the accepted item
   always @(posedge clock) begin
      meter_reading_type exp_rd;
      meter_reading_type got_rd;
      req_taken = 1'b0;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got_rd.measured_hz = rsp_tdata[31:0];
            got_rd.lamp_bar    = rsp_tdata[35:32];
            got_rd.zero_period = rsp_tuser[0];
            if (expected_readings.size() == 0) begin
               errors++;
               if (errors <= MAX_REPORTS)
                  $display("ERROR: unexpected item hz=%0d lamps=%b zero=%b",
                           got_rd.measured_hz, got_rd.lamp_bar, got_rd.zero_period);
            end else begin
               exp_rd = expected_readings.pop_front();
               readings_checked++;
               if (exp_rd.zero_period) zero_flags++;
               if (got_rd != exp_rd) begin
                  errors++;
                  if (errors <= MAX_REPORTS)
                     $display({"ERROR: item %0d exp hz=%0d lamps=%b zero=%b",
                               " got hz=%0d lamps=%b zero=%b"},
                              readings_checked, exp_rd.measured_hz, exp_rd.lamp_bar,
                              exp_rd.zero_period, got_rd.measured_hz, got_rd.lamp_bar,
                              got_rd.zero_period);
               end
            end
            rsp_stall = $urandom_range(0, idle_max);
         end
         if (req_tvalid && req_tready) begin
            req_taken = 1'b1;
            items_sent++;
            if (predict_meter(req_tdata, exp_rd)) expected_readings.push_back(exp_rd);
            req_gap = $urandom_range(0, idle_max);
         end
      end
   end

   // driver: inputs move on the falling edge
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (req_tvalid && !req_taken) begin
      end else if (req_gap > 0) begin
         req_gap--;
         req_tvalid <= 1'b0;
      end else if (capture_queue.size() > 0) begin
         req_tdata  <= capture_queue.pop_front();
         req_tvalid <= 1'b1;
      end else begin
         req_tvalid <= 1'b0;
      end
      if (rsp_stall > 0) begin
         rsp_stall--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= !reset;
      end
   end

   task automatic csr_write(input logic [1:0] idx, input logic [31:0] data);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      case (idx)
         cfmb_pkg::CSR_CLOCK_RATE: cfg_clock_rate = data;
         cfmb_pkg::CSR_PRESCALE:   cfg_prescale   = data[16:0];
         cfmb_pkg::CSR_LEVEL_STEP: cfg_level_step = data[29:0];
         default: begin
         end
      endcase
      csr_writes++;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic wait_idle();
      while (capture_queue.size() != 0 || req_tvalid || expected_readings.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic push_capture(input logic [31:0] value);
      last_capture = value;
      capture_queue.push_back(value);
   endtask

   task automatic queue_random(input int count);
      int mode;
      logic [31:0] delta;
      for (int k = 0; k < count; k++) begin
         mode = $urandom_range(0, 9);
         case (mode)
            0:       delta = 32'd0;
            1, 2:    delta = $urandom_range(1, 16);
            3, 4, 5: delta = $urandom_range(1, 1 << 20);
            6:       delta = $urandom_range(1, 1 << 26);
            7:       delta = $urandom;
            default: delta = 32'd0;
         endcase
         if (mode >= 8) push_capture($urandom);
         else push_capture(last_capture + delta);
      end
   endtask

   task automatic set_config(input logic [31:0] rate, input logic [31:0] presc,
                             input logic [31:0] step);
      csr_write(cfmb_pkg::CSR_CLOCK_RATE, rate);
      csr_write(cfmb_pkg::CSR_PRESCALE, presc);
      csr_write(cfmb_pkg::CSR_LEVEL_STEP, step);
   endtask

   initial begin
      have_prev      = 1'b0;
      prev_capture   = '0;
      cfg_clock_rate = cfmb_pkg::CLOCK_RATE_RESET;
      cfg_prescale   = cfmb_pkg::PRESCALE_RESET;
      cfg_level_step = cfmb_pkg::LEVEL_STEP_RESET;
      last_capture   = '0;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: reset defaults, equal captures, wrap, lamp thresholds
      push_capture(32'd0);
      push_capture(32'd0);
      push_capture(32'd1);
      push_capture(32'hFFFF_FFFF);
      push_capture(32'd0);
      push_capture(32'd100000);
      push_capture(32'd200001);
      push_capture(32'd250001);
      push_capture(32'd283334);
      push_capture(32'd308334);
      push_capture(32'hAAAA_AAAA);
      push_capture(32'h5555_5555);
      wait_idle();
      csr_write(cfmb_pkg::CSR_PRESCALE, 32'h0002_0000);   // masks to zero prescale
      push_capture(last_capture + 32'd5);
      wait_idle();
      csr_write(cfmb_pkg::CSR_PRESCALE, 32'd65536);       // product wraps to zero
      push_capture(last_capture + 32'd65536);
      push_capture(last_capture + 32'd1);
      wait_idle();
      set_config(32'd0, 32'd1, 32'd0);          // zero rate, zero step
      push_capture(last_capture + 32'd7);
      wait_idle();
      csr_write(cfmb_pkg::CSR_LEVEL_STEP, 32'd1000);
      push_capture(last_capture + 32'd3);
      wait_idle();
      set_config(32'hFFFF_FFFF, 32'd1, 32'hFFFF_FFFF);
      push_capture(last_capture + 32'd1);
      push_capture(last_capture + 32'd2);
      wait_idle();
      csr_write(CSR_UNMAPPED, $urandom);
      push_capture(last_capture);
      push_capture(last_capture + 32'd3);

      // random phases over several settings
      wait_idle();
      set_config(cfmb_pkg::CLOCK_RATE_RESET, 32'(cfmb_pkg::PRESCALE_RESET),
                 32'(cfmb_pkg::LEVEL_STEP_RESET));
      queue_random(150);
      wait_idle();
      set_config($urandom, $urandom_range(1, 16), $urandom_range(0, 1 << 22));
      queue_random(100);
      wait_idle();
      idle_max = 0;
      set_config(cfmb_pkg::CLOCK_RATE_RESET, 32'd1, 32'd50000);
      queue_random(100);
      wait_idle();
      idle_max = 5;
      set_config(32'hFFFF_FFFF, 32'd1, 32'h3FFF_FFFF);
      queue_random(100);
      wait_idle();
      set_config(32'd1, 32'd65536, 32'd0);
      queue_random(50);
      wait_idle();
      set_config($urandom, $urandom_range(1, 65536), $urandom);
      queue_random(150);
      wait_idle();

      $display("Sent %0d captures over %0d register writes;", items_sent, csr_writes);
      $display("checked %0d results (%0d zero-period).", readings_checked, zero_flags);
      if (errors == 0 && expected_readings.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Mismatches: %0d, results still owed: %0d", errors, expected_readings.size());
         $display("Simulation FAILED");
      end
      $finish;
   end

   initial begin
      #(CLOCK_PERIOD * TIMEOUT_CYCLES);
      $display("Timeout with %0d results still owed", expected_readings.size());
      $display("Simulation FAILED");
      $finish;
   end

endmodule
